@@ rtl/apf_pkg.sv @@
// Package: shared constants and pipeline payload types for the agent pair force block.
`default_nettype none
package apf_pkg;
  localparam int unsigned RegCount = 3;
  localparam logic [1:0] REG_MIN_APPROACH = 2'd0;
  localparam logic [1:0] REG_CONSP_GAIN   = 2'd1;
  localparam logic [1:0] REG_PRED_GAIN    = 2'd2;
  localparam logic [15:0] GainReset = 16'd256;
  localparam int unsigned SqrtSteps = 17;
  localparam int unsigned DivSteps  = 16;

  // per item side data that travels along the sqrt stages
  typedef struct packed {
    logic        kind;
    logic [15:0] adx;
    logic [15:0] ady;
    logic        negx;
    logic        negy;
    logic        coinc;
  } pl_t;

  // side data along the divider stages
  typedef struct packed {
    logic        negx;
    logic        negy;
    logic        coinc;
    logic [16:0] span;
  } dpl_t;
endpackage
`default_nettype wire

@@ rtl/agent_pair_force_top.sv @@
// Agent pair force: difference vector, pipelined sqrt and dividers, scaled unit force.
// A request passes the difference, square, sum, sqrt, numerator, divider and output registers before done_o is high.
// Throughput: one request per cycle; busy_o is always low and results cannot be held off.
// Depth is set by the 17 one-bit sqrt stages and the 16 one-bit divider stages.
// Reset (rst_ni low, async) clears all valid bits; the three configuration registers return to 256.
`default_nettype none
module agent_pair_force_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        kind_i,
  input  wire logic [15:0] self_x_i,
  input  wire logic [15:0] self_y_i,
  input  wire logic [15:0] other_x_i,
  input  wire logic [15:0] other_y_i,
  output logic             done_o,
  output logic [15:0]      force_x_o,
  output logic [15:0]      force_y_o,
  output logic             coincident_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import apf_pkg::*;

  logic [15:0] min_app_q, cgain_q, pgain_q;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign busy_o  = 1'b0;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_app_q <= GainReset;
      cgain_q   <= GainReset;
      pgain_q   <= GainReset;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_MIN_APPROACH: min_app_q <= pwdata[15:0];
        REG_CONSP_GAIN:   cgain_q   <= pwdata[15:0];
        REG_PRED_GAIN:    pgain_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_APPROACH: prdata = {16'd0, min_app_q};
      REG_CONSP_GAIN:   prdata = {16'd0, cgain_q};
      REG_PRED_GAIN:    prdata = {16'd0, pgain_q};
      default:          prdata = 32'd0;
    endcase
  end

  // stage 1: differences
  logic               v1_q;
  logic               k1_q;
  logic signed [16:0] dx1_q, dy1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    k1_q  <= kind_i;
    dx1_q <= $signed({other_x_i[15], other_x_i}) - $signed({self_x_i[15], self_x_i});
    dy1_q <= $signed({other_y_i[15], other_y_i}) - $signed({self_y_i[15], self_y_i});
  end

  // stage 2: squares
  logic               v2_q, k2_q;
  logic signed [16:0] dx2_q, dy2_q;
  logic [31:0]        sqx2_q, sqy2_q, ma_sq2_q;
  logic signed [33:0] sqx_w, sqy_w;
  assign sqx_w = dx1_q * dx1_q;
  assign sqy_w = dy1_q * dy1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    k2_q     <= k1_q;
    dx2_q    <= dx1_q;
    dy2_q    <= dy1_q;
    sqx2_q   <= sqx_w[31:0];
    sqy2_q   <= sqy_w[31:0];
    ma_sq2_q <= min_app_q * min_app_q;
  end

  // stage 3: sum, closeness, signs
  logic [32:0] s_w;
  logic        repel_w;
  assign s_w     = {1'b0, sqx2_q} + {1'b0, sqy2_q};
  assign repel_w = k2_q || (s_w < {1'b0, ma_sq2_q});

  logic        sv_q [0:SqrtSteps];
  pl_t         sp_q [0:SqrtSteps];
  logic [33:0] ss_q [0:SqrtSteps];
  logic [19:0] sr_q [0:SqrtSteps];
  logic [16:0] sroot_q [0:SqrtSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q[0] <= 1'b0;
    else         sv_q[0] <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    sp_q[0].kind  <= k2_q;
    sp_q[0].adx   <= dx2_q[16] ? 16'(-dx2_q) : dx2_q[15:0];
    sp_q[0].ady   <= dy2_q[16] ? 16'(-dy2_q) : dy2_q[15:0];
    sp_q[0].negx  <= dx2_q[16] ^ repel_w;
    sp_q[0].negy  <= dy2_q[16] ^ repel_w;
    sp_q[0].coinc <= (s_w == 33'd0);
    ss_q[0]       <= {1'b0, s_w};
    sr_q[0]       <= 20'd0;
    sroot_q[0]    <= 17'd0;
  end

  // restoring sqrt, one root bit per stage
  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    logic [19:0] rem_w, trial_w;
    assign rem_w   = {sr_q[g][17:0], ss_q[g][33:32]};
    assign trial_w = {1'b0, sroot_q[g], 2'b01};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[g+1] <= 1'b0;
      else         sv_q[g+1] <= sv_q[g];
    end
    always_ff @(posedge clk_i) begin
      sp_q[g+1] <= sp_q[g];
      ss_q[g+1] <= {ss_q[g][31:0], 2'b00};
      if (rem_w >= trial_w) begin
        sr_q[g+1]    <= rem_w - trial_w;
        sroot_q[g+1] <= {sroot_q[g][15:0], 1'b1};
      end else begin
        sr_q[g+1]    <= rem_w;
        sroot_q[g+1] <= {sroot_q[g][15:0], 1'b0};
      end
    end
  end

  // numerators: gain times |delta|
  logic [15:0] gain_w;
  assign gain_w = sp_q[SqrtSteps].kind ? pgain_q : cgain_q;

  logic        dv_q [0:DivSteps];
  dpl_t        dp_q [0:DivSteps];
  logic [16:0] xr_q [0:DivSteps];
  logic [16:0] yr_q [0:DivSteps];
  logic [15:0] xl_q [0:DivSteps];
  logic [15:0] yl_q [0:DivSteps];
  logic [15:0] xq_q [0:DivSteps];
  logic [15:0] yq_q [0:DivSteps];
  logic [31:0] nx_w, ny_w;
  assign nx_w = gain_w * sp_q[SqrtSteps].adx;
  assign ny_w = gain_w * sp_q[SqrtSteps].ady;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q[0] <= 1'b0;
    else         dv_q[0] <= sv_q[SqrtSteps];
  end
  always_ff @(posedge clk_i) begin
    dp_q[0].negx  <= sp_q[SqrtSteps].negx;
    dp_q[0].negy  <= sp_q[SqrtSteps].negy;
    dp_q[0].coinc <= sp_q[SqrtSteps].coinc;
    dp_q[0].span  <= sroot_q[SqrtSteps];
    // quotient fits 16 bits since it never exceeds the gain
    xr_q[0] <= {1'b0, nx_w[31:16]};
    yr_q[0] <= {1'b0, ny_w[31:16]};
    xl_q[0] <= nx_w[15:0];
    yl_q[0] <= ny_w[15:0];
    xq_q[0] <= 16'd0;
    yq_q[0] <= 16'd0;
  end

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    logic [17:0] tx_w, ty_w, dd_w;
    logic        bx_w, by_w;
    assign tx_w = {xr_q[g], xl_q[g][15]};
    assign ty_w = {yr_q[g], yl_q[g][15]};
    assign dd_w = {1'b0, dp_q[g].span};
    assign bx_w = tx_w >= dd_w;
    assign by_w = ty_w >= dd_w;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[g+1] <= 1'b0;
      else         dv_q[g+1] <= dv_q[g];
    end
    always_ff @(posedge clk_i) begin
      dp_q[g+1] <= dp_q[g];
      xl_q[g+1] <= {xl_q[g][14:0], 1'b0};
      yl_q[g+1] <= {yl_q[g][14:0], 1'b0};
      xr_q[g+1] <= bx_w ? 17'(tx_w - dd_w) : tx_w[16:0];
      yr_q[g+1] <= by_w ? 17'(ty_w - dd_w) : ty_w[16:0];
      xq_q[g+1] <= {xq_q[g][14:0], bx_w};
      yq_q[g+1] <= {yq_q[g][14:0], by_w};
    end
  end

  // sign and saturate
  function automatic logic [15:0] sat_fn(input logic [15:0] mag, input logic neg);
    logic [15:0] r;
    if (neg) r = (mag > 16'd32768) ? 16'h8000 : 16'(-mag);
    else     r = (mag > 16'd32767) ? 16'h7fff : mag;
    return r;
  endfunction

  logic done_q, coinc_q;
  logic [15:0] fx_q, fy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= dv_q[DivSteps];
  end
  always_ff @(posedge clk_i) begin
    coinc_q <= dp_q[DivSteps].coinc;
    fx_q    <= dp_q[DivSteps].coinc ? 16'd0 : sat_fn(xq_q[DivSteps], dp_q[DivSteps].negx);
    fy_q    <= dp_q[DivSteps].coinc ? 16'd0 : sat_fn(yq_q[DivSteps], dp_q[DivSteps].negy);
  end

  assign done_o       = done_q;
  assign force_x_o    = fx_q;
  assign force_y_o    = fy_q;
  assign coincident_o = coinc_q;
endmodule
`default_nettype wire

@@ rtl/apf_checker.sv @@
// Checker: port-level properties of the agent pair force block, bound to the top level.
`default_nettype none
module apf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic [15:0] force_x_o,
  input wire logic [15:0] force_y_o,
  input wire logic        coincident_o,
  input wire logic        pready
);
  localparam int unsigned Latency = 37;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o && pready)
    else $error("block refused a request");

  // done_o is sampled at the edge after it rises
  a_done_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency + 1))
    else $error("result without a matching request");

  a_coinc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && coincident_o) |-> (force_x_o == 16'd0 && force_y_o == 16'd0))
    else $error("coincident result with nonzero force");
endmodule

bind agent_pair_force_top apf_checker u_apf_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .done_o(done_o), .force_x_o(force_x_o), .force_y_o(force_y_o),
  .coincident_o(coincident_o), .pready(pready)
);
`default_nettype wire
